// ----- sv/imu_frm_pkg.sv -----
// imu_frm_pkg: shared types and constants of the imu frame deframer
// no dependencies; used by the top, front, queue and back modules
package imu_frm_pkg;

    // reset value of the sync register
    localparam logic [7:0] SYNC_RESET = 8'h55;

    // number of payload words carried on the result channel
    localparam int OUT_WORDS = 4;

    // raw frame record passed from front to back: type byte and payload bytes
    typedef struct packed {
        logic [7:0]                      msg_kind;
        logic [2*OUT_WORDS-1:0][7:0]     pay;
    } t_raw;

endpackage

// ----- sv/imu_frm_ifs.sv -----
// imu_frm_ifs: valid/ready channel interfaces of the imu frame deframer
// standalone; byte request in, decoded frame request out
interface imu_frm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_frm_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         msg_kind;
    logic signed [15:0] word_zero;
    logic signed [15:0] word_one;
    logic signed [15:0] word_two;
    logic signed [15:0] word_three;

    modport source (output valid, output msg_kind, output word_zero, output word_one,
                    output word_two, output word_three, input ready);
    modport sink   (input valid, input msg_kind, input word_zero, input word_one,
                    input word_two, input word_three, output ready);
endinterface

// ----- sv/imu_frame_deframer.sv -----
// imu_frame_deframer: takes one received byte per request and emits one decoded frame
// request for every frame whose first byte matches the sync register and whose last
// byte equals the 8-bit sum of the bytes before it; a failed check drops the oldest
// byte and keeps sliding. Bytes are taken at one per clock cycle: the frame check
// uses a running byte sum kept in a register next to the byte window, so the check
// is one compare per byte. A good frame goes from the window through the frame queue into
// the output register. Byte ready drops only while the two-entry frame queue between the
// window and the output register is full. No clearing pass after reset.
// Depends on imu_frm_pkg, imu_frm_ifs, imu_frm_front, imu_frm_fifo and imu_frm_back.
module imu_frame_deframer #(
    parameter int PAYLOAD_WORDS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    imu_frm_byte_if.sink     i_byte,
    imu_frm_result_if.source o_frame
);
    import imu_frm_pkg::*;

    logic q_push, q_full, q_valid, q_pop;
    t_raw q_in, q_out;

    // window and frame check
    imu_frm_front #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (i_byte),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_raw         (q_in)
    );

    // frame queue
    imu_frm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    // word assembly and result register
    imu_frm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_frame   (o_frame)
    );

endmodule

// ----- sv/imu_frm_front.sv -----
// imu_frm_front: byte window, running checksum and frame check
// depends on imu_frm_pkg and imu_frm_byte_if
module imu_frm_front #(
    parameter int PAYLOAD_WORDS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    imu_frm_byte_if.sink         i_byte,
    input  logic                 i_q_full,
    output logic                 o_push,
    output imu_frm_pkg::t_raw    o_raw
);
    import imu_frm_pkg::*;

    localparam int WIN_LEN = 2 + 2 * PAYLOAD_WORDS;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(WIN_LEN);

    logic [7:0]       r_win [WIN_LEN];
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_sync;

    logic accept, full, good, slide, append;

    // request handshake and frame check
    assign i_byte.ready = !i_q_full;
    assign accept = i_byte.valid && i_byte.ready;
    assign full   = (r_fill == WIN_FULL);
    assign good   = full && (r_win[0] == r_sync) && (r_sum == i_byte.rx_byte);
    assign append = accept && !full;
    assign slide  = accept && full && !good;
    assign o_push = accept && good;

    // fill count and running byte sum of the window
    always_comb begin
        n_fill = r_fill;
        n_sum  = r_sum;
        if (append) begin
            n_fill = r_fill + CNT_W'(1);
            n_sum  = r_sum + i_byte.rx_byte;
        end else if (o_push) begin
            n_fill = '0;
            n_sum  = '0;
        end else if (slide) begin
            n_sum = r_sum - r_win[0] + i_byte.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
            r_sync <= SYNC_RESET;
        end else begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
            if (i_cfg_wr_en) begin
                r_sync <= i_cfg_wr_data;
            end
        end
    end

    // window entries: append at the fill position or shift down by one
    generate
        for (genvar k = 0; k < WIN_LEN; k++) begin : g_win
            always_ff @(posedge i_clk) begin
                if (slide) begin
                    if (k == WIN_LEN - 1) begin
                        r_win[k] <= i_byte.rx_byte;
                    end else begin
                        r_win[k] <= r_win[(k + 1) % WIN_LEN];
                    end
                end else if (append && r_fill == CNT_W'(k)) begin
                    r_win[k] <= i_byte.rx_byte;
                end
            end
        end
    endgenerate

    // frame record; payload bytes past the frame read as zero
    assign o_raw.msg_kind = r_win[1];
    generate
        for (genvar j = 0; j < 2 * OUT_WORDS; j++) begin : g_pay
            if (j < 2 * PAYLOAD_WORDS) begin : g_used
                assign o_raw.pay[j] = r_win[2 + j];
            end else begin : g_zero
                assign o_raw.pay[j] = 8'h00;
            end
        end
    endgenerate

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_FULL)
        else $error("window fill count past frame length");

    a_slide_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slide |=> (r_fill == WIN_FULL))
        else $error("window lost entries on resync slide");

    a_good_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_fill == '0) && (r_sum == 8'h00))
        else $error("window not emptied after good frame");

endmodule

// ----- sv/imu_frm_fifo.sv -----
// imu_frm_fifo: two-entry queue of frame records between front and back
// depends on imu_frm_pkg
module imu_frm_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  imu_frm_pkg::t_raw    i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_pop,
    output imu_frm_pkg::t_raw    o_data
);
    import imu_frm_pkg::*;

    t_raw       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("frame queue written while full");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("frame queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("frame queue pointers disagree with count");

endmodule

// ----- sv/imu_frm_back.sv -----
// imu_frm_back: assembles signed payload words and holds the result register
// depends on imu_frm_pkg and imu_frm_result_if
module imu_frm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  imu_frm_pkg::t_raw    i_q_data,
    output logic                 o_q_pop,
    imu_frm_result_if.source     o_frame
);
    import imu_frm_pkg::*;

    logic                      r_valid;
    logic [7:0]                r_type;
    logic signed [15:0]        r_word [OUT_WORDS];
    logic signed [15:0]        n_word [OUT_WORDS];

    // load a new result when the register is empty or being taken
    assign o_q_pop = i_q_valid && (!r_valid || o_frame.ready);

    // little-endian word assembly
    always_comb begin
        for (int k = 0; k < OUT_WORDS; k++) begin
            n_word[k] = signed'({i_q_data.pay[2*k+1], i_q_data.pay[2*k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_type <= i_q_data.msg_kind;
            r_word <= n_word;
        end
    end

    // result channel
    assign o_frame.valid      = r_valid;
    assign o_frame.msg_kind   = r_type;
    assign o_frame.word_zero  = r_word[0];
    assign o_frame.word_one   = r_word[1];
    assign o_frame.word_two   = r_word[2];
    assign o_frame.word_three = r_word[3];

endmodule
